// ===== src/flptw_pkg.sv =====
// Package for the four-level page table walker: item structs, command and
// status codes, store geometry and the level index helper.
// No dependencies.
package flptw_pkg;

    localparam int TABLE_FRAMES = 16;
    localparam int ENTRIES_PER_FRAME = 512;
    localparam int FRAME_IDX_W = $clog2(TABLE_FRAMES);
    localparam int FRAME_CNT_W = $clog2(TABLE_FRAMES + 1);
    localparam int STORE_DEPTH = TABLE_FRAMES * ENTRIES_PER_FRAME;
    localparam int STORE_AW = FRAME_IDX_W + 9;

    localparam logic [1:0] CMD_MAP = 2'd0;
    localparam logic [1:0] CMD_UNMAP = 2'd1;
    localparam logic [1:0] CMD_RESOLVE = 2'd2;
    localparam logic [1:0] CMD_TRANSLATE = 2'd3;

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_MISSING = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    localparam logic [63:0] KERNEL_HALF_BASE = 64'hFFFF_8000_0000_0000;

    localparam logic [1:0] LVL_LEAF = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [63:0] virtual_address;
        logic [63:0] physical_address;
        logic [11:0] page_flags;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] result_address;
    } out_item_t;

    function automatic logic [8:0] level_index(input logic [63:0] va, input logic [1:0] lvl);
        logic [8:0] idx;
        case (lvl)
            2'd0:    idx = va[47:39];
            2'd1:    idx = va[38:30];
            2'd2:    idx = va[29:21];
            default: idx = va[20:12];
        endcase
        return idx;
    endfunction

endpackage

// ===== src/flptw_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module flptw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/four_level_page_table_walker.sv =====
// Top level of the four-level page table walker.
// Depends on flptw_pkg and flptw_ram.
//
// The page table lives in one RAM of TABLE_FRAMES frames of 512 entries, root
// in frame 0. After reset the block zeroes the whole store, one entry a cycle,
// and accepts no item meanwhile; the config port works throughout. An item is
// taken in IDLE and checked in START, then each table level visited passes a
// RAM read state and an evaluate state, and DONE loads the output register once
// it is free. Map writes its leaf without a read, a direct-map translate skips
// the walk, and a miss or full store ends the walk early.
module four_level_page_table_walker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  flptw_pkg::in_item_t  s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output flptw_pkg::out_item_t m_item,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [63:0]          pwdata,
    output logic [63:0]          prdata,
    output logic                 pready
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_EVAL  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    localparam logic [flptw_pkg::STORE_AW-1:0] CLEAR_LAST =
        flptw_pkg::STORE_AW'(flptw_pkg::STORE_DEPTH - 1);

    logic [2:0]                          state_reg, state_next;
    flptw_pkg::in_item_t                 item_reg, item_next;
    logic [1:0]                          lvl_reg, lvl_next;
    logic [flptw_pkg::FRAME_IDX_W-1:0]   frame_reg, frame_next;
    logic [flptw_pkg::FRAME_CNT_W-1:0]   nff_reg, nff_next;
    logic [flptw_pkg::STORE_AW-1:0]      clr_reg, clr_next;
    logic [63:0]                         off_reg, off_next;
    logic [1:0]                          stat_reg, stat_next;
    logic [63:0]                         res_reg, res_next;
    logic                                m_valid_reg, m_valid_next;
    flptw_pkg::out_item_t                m_item_reg, m_item_next;

    logic                                ram_we;
    logic [flptw_pkg::STORE_AW-1:0]      ram_waddr, ram_raddr, walk_addr;
    logic [63:0]                         ram_wdata, ram_rdata;
    logic                                entry_ok, cfg_wr;

    flptw_ram #(
        .WIDTH(64),
        .DEPTH(flptw_pkg::STORE_DEPTH)
    ) u_store (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign walk_addr = {frame_reg, flptw_pkg::level_index(item_reg.virtual_address, lvl_reg)};
    assign entry_ok  = ram_rdata[0] &&
                       (ram_rdata[63:12] < 52'(flptw_pkg::TABLE_FRAMES));

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && !paddr[3];
    assign prdata = paddr[3] ? 64'd0 : off_reg;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    always_comb begin
        state_next   = state_reg;
        item_next    = item_reg;
        lvl_next     = lvl_reg;
        frame_next   = frame_reg;
        nff_next     = nff_reg;
        clr_next     = clr_reg;
        off_next     = cfg_wr ? pwdata : off_reg;
        stat_next    = stat_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        ram_we       = 1'b0;
        ram_waddr    = walk_addr;
        ram_wdata    = 64'd0;
        ram_raddr    = walk_addr;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == CLEAR_LAST) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    item_next  = s_item;
                    lvl_next   = 2'd0;
                    frame_next = '0;
                    state_next = S_START;
                end
            end
            S_START: begin
                if (item_reg.command == flptw_pkg::CMD_TRANSLATE &&
                    item_reg.virtual_address >= off_reg) begin
                    stat_next  = flptw_pkg::STATUS_OK;
                    res_next   = item_reg.virtual_address - off_reg;
                    state_next = S_DONE;
                end else begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                if (item_reg.command == flptw_pkg::CMD_MAP && lvl_reg == flptw_pkg::LVL_LEAF) begin
                    ram_we     = 1'b1;
                    ram_wdata  = {item_reg.physical_address[63:12],
                                  item_reg.page_flags | 12'h001};
                    stat_next  = flptw_pkg::STATUS_OK;
                    res_next   = 64'd0;
                    state_next = S_DONE;
                end else begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                state_next = S_DONE;
                res_next   = 64'd0;
                if (lvl_reg != flptw_pkg::LVL_LEAF) begin
                    if (entry_ok) begin
                        frame_next = ram_rdata[12 +: flptw_pkg::FRAME_IDX_W];
                        lvl_next   = lvl_reg + 1'b1;
                        state_next = S_READ;
                    end else if (item_reg.command == flptw_pkg::CMD_MAP) begin
                        if (nff_reg >= flptw_pkg::FRAME_CNT_W'(flptw_pkg::TABLE_FRAMES)) begin
                            stat_next = flptw_pkg::STATUS_FULL;
                        end else begin
                            // new frame is already zero from the clearing pass
                            ram_we     = 1'b1;
                            ram_wdata  = {{(52 - flptw_pkg::FRAME_IDX_W){1'b0}},
                                          nff_reg[flptw_pkg::FRAME_IDX_W-1:0], 12'd0};
                            ram_wdata  = ram_wdata | 64'h3 |
                                (item_reg.virtual_address < flptw_pkg::KERNEL_HALF_BASE ?
                                 64'h4 : 64'h0);
                            frame_next = nff_reg[flptw_pkg::FRAME_IDX_W-1:0];
                            nff_next   = nff_reg + 1'b1;
                            lvl_next   = lvl_reg + 1'b1;
                            state_next = S_READ;
                        end
                    end else begin
                        stat_next = flptw_pkg::STATUS_MISSING;
                    end
                end else begin
                    stat_next = ram_rdata[0] ? flptw_pkg::STATUS_OK : flptw_pkg::STATUS_MISSING;
                    if (item_reg.command == flptw_pkg::CMD_UNMAP) begin
                        ram_we = 1'b1;
                    end else if (ram_rdata[0]) begin
                        res_next = {ram_rdata[63:12], item_reg.virtual_address[11:0]};
                    end
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_item_next.status         = stat_reg;
                    m_item_next.result_address = res_reg;
                    m_valid_next               = 1'b1;
                    state_next                 = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            lvl_reg     <= 2'd0;
            frame_reg   <= '0;
            nff_reg     <= flptw_pkg::FRAME_CNT_W'(1);
            clr_reg     <= '0;
            off_reg     <= 64'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            lvl_reg     <= lvl_next;
            frame_reg   <= frame_next;
            nff_reg     <= nff_next;
            clr_reg     <= clr_next;
            off_reg     <= off_next;
            m_valid_reg <= m_valid_next;
        end
        item_reg   <= item_next;
        stat_reg   <= stat_next;
        res_reg    <= res_next;
        m_item_reg <= m_item_next;
    end

endmodule

// ===== src/flptw_checker.sv =====
// Port-level checker for the page table walker, bound to the top level.
// Depends on flptw_pkg and four_level_page_table_walker.
module flptw_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input flptw_pkg::out_item_t m_item
);

    // a stalled result item holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result item changed while stalled");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_item.status != 2'd3)
        else $error("undefined status code");

    a_zero_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.status != flptw_pkg::STATUS_OK |-> m_item.result_address == 64'd0)
        else $error("nonzero address on failed item");

    // one item at a time: intake closes right after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item taken while walking");

endmodule

bind four_level_page_table_walker flptw_checker u_flptw_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_item (m_item)
);
